### hw/rtl/pcmdm_pkg.sv
// ----------------------------------------------------------------------------
// PCM downmix package
// Shared widths, reset values, register indexes and bundle types of the block.
// ----------------------------------------------------------------------------
package pcmdm_pkg;

  localparam int unsigned MAX_CHANNELS_DEF = 8;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned PCM_W    = 16;
  localparam int unsigned SUM_W    = 20;
  localparam int unsigned SB_W     = 3;
  localparam int unsigned CC_W     = 4;
  localparam int unsigned CHAN_W   = 5;

  localparam int PCM_MIN = -32768;
  localparam int PCM_MAX = 32767;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [SB_W-1:0] SB_RESET = 3'd2;
  localparam logic [CC_W-1:0] CC_RESET = 4'd2;

  localparam logic [SB_W-1:0] SB_ONE   = 3'd1;
  localparam logic [SB_W-1:0] SB_TWO   = 3'd2;
  localparam logic [SB_W-1:0] SB_THREE = 3'd3;
  localparam logic [SB_W-1:0] SB_FOUR  = 3'd4;

  localparam logic [7:0] U8_OFFSET = 8'd128;

  typedef enum logic {
    REG_SAMPLE_BYTES  = 1'b0,
    REG_CHANNEL_COUNT = 1'b1
  } pcmdm_reg_e;

  typedef struct packed {
    logic [SB_W-1:0] sample_bytes;
    logic [CC_W-1:0] channel_count;
  } pcmdm_cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_word;
    logic                end_of_block;
  } pcmdm_item_t;

  typedef struct packed {
    logic        valid;
    pcmdm_item_t item;
  } pcmdm_stage_t;

endpackage

### hw/rtl/pcmdm_sample_if.sv
// ----------------------------------------------------------------------------
// PCM sample channel
// Valid/ready channel that carries one raw channel sample per transfer.
// ----------------------------------------------------------------------------
interface pcmdm_sample_if;
  logic                          valid;
  logic                          ready;
  logic [pcmdm_pkg::SAMPLE_W-1:0] sample_word;
  logic                          end_of_block;

  modport source (output valid, output sample_word, output end_of_block, input ready);
  modport sink   (input valid, input sample_word, input end_of_block, output ready);
endinterface

### hw/rtl/pcmdm_result_if.sv
// ----------------------------------------------------------------------------
// PCM stereo result channel
// Valid/ready channel that carries one saturated stereo frame per transfer.
// ----------------------------------------------------------------------------
interface pcmdm_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [pcmdm_pkg::PCM_W-1:0] left_out;
  logic signed [pcmdm_pkg::PCM_W-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

### hw/rtl/pcmdm_cfg_regs.sv
// ----------------------------------------------------------------------------
// PCM downmix configuration registers
// APB-style register file holding the sample size and the channel count.
// ----------------------------------------------------------------------------
module pcmdm_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pcmdm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pcmdm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pcmdm_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready,
  output pcmdm_pkg::pcmdm_cfg_t            cfg_o
);
  import pcmdm_pkg::*;

  pcmdm_cfg_t cfg_q;
  pcmdm_reg_e reg_sel;
  logic       wr_en;

  assign reg_sel = pcmdm_reg_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_bytes  <= SB_RESET;
      cfg_q.channel_count <= CC_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SAMPLE_BYTES:  cfg_q.sample_bytes  <= pwdata[SB_W-1:0];
        REG_CHANNEL_COUNT: cfg_q.channel_count <= pwdata[CC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SAMPLE_BYTES:  prdata = APB_DATA_W'(cfg_q.sample_bytes);
      REG_CHANNEL_COUNT: prdata = APB_DATA_W'(cfg_q.channel_count);
      default:           prdata = '0;
    endcase
  end

endmodule

### hw/rtl/pcmdm_input_stage.sv
// ----------------------------------------------------------------------------
// PCM downmix input stage
// Registers each accepted sample and holds it until the core takes it.
// ----------------------------------------------------------------------------
module pcmdm_input_stage (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  pcmdm_sample_if.sink            sample_i,
  input  logic                    advance_i,
  output pcmdm_pkg::pcmdm_stage_t stage_o
);
  import pcmdm_pkg::*;

  logic        valid_q;
  logic        valid_d;
  pcmdm_item_t item_q;
  logic        accept;

  assign sample_i.ready = !valid_q || advance_i;
  assign accept         = sample_i.valid && sample_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.sample_word  <= sample_i.sample_word;
      item_q.end_of_block <= sample_i.end_of_block;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

### hw/rtl/pcmdm_core.sv
// ----------------------------------------------------------------------------
// PCM downmix core
// Converts one sample to 16 bits, accumulates the frame and registers results.
// ----------------------------------------------------------------------------
module pcmdm_core #(
  parameter int unsigned MAX_CHANNELS = pcmdm_pkg::MAX_CHANNELS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pcmdm_pkg::pcmdm_cfg_t   cfg_i,
  input  pcmdm_pkg::pcmdm_stage_t stage_i,
  output logic                    advance_o,
  pcmdm_result_if.source          result_o
);
  import pcmdm_pkg::*;

  localparam int unsigned POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [CHAN_W-1:0] MAX_CH = CHAN_W'(MAX_CHANNELS);

  function automatic logic signed [PCM_W-1:0] clamp16(input logic signed [SUM_W-1:0] v);
    logic signed [PCM_W-1:0] r;
    if (v < SUM_W'(PCM_MIN)) begin
      r = PCM_W'(PCM_MIN);
    end else if (v > SUM_W'(PCM_MAX)) begin
      r = PCM_W'(PCM_MAX);
    end else begin
      r = v[PCM_W-1:0];
    end
    return r;
  endfunction

  logic signed [SUM_W-1:0] left_sum_q, left_sum_d;
  logic signed [SUM_W-1:0] right_sum_q, right_sum_d;
  logic        [POS_W-1:0] pos_q, pos_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [PCM_W-1:0] left_q, left_d;
  logic signed [PCM_W-1:0] right_q, right_d;

  logic [SAMPLE_W-1:0]     word;
  logic [CHAN_W-1:0]       cc_ext;
  logic [CHAN_W-1:0]       chans;
  logic [CHAN_W-1:0]       pos_inc;
  logic                    size_ok;
  logic signed [PCM_W-1:0] value;
  logic signed [PCM_W-1:0] bias;
  logic signed [PCM_W-1:0] half;
  logic signed [SUM_W-1:0] value_ext;
  logic signed [SUM_W-1:0] half_ext;
  logic signed [SUM_W-1:0] left_new;
  logic signed [SUM_W-1:0] right_new;
  logic signed [PCM_W-1:0] left_sat;

  assign word = stage_i.item.sample_word;

  always_comb begin
    cc_ext = CHAN_W'(cfg_i.channel_count);
    chans  = (cc_ext == '0) ? CHAN_W'(2) : cc_ext;
    if (chans > MAX_CH) begin
      chans = MAX_CH;
    end
  end

  always_comb begin
    size_ok = 1'b1;
    case (cfg_i.sample_bytes)
      SB_ONE:   value = $signed({word[7:0] - U8_OFFSET, 8'h00});
      SB_TWO:   value = $signed(word[15:0]);
      SB_THREE: value = $signed(word[23:8]);
      SB_FOUR:  value = $signed(word[31:16]);
      default: begin
        value   = '0;
        size_ok = 1'b0;
      end
    endcase
  end

  // Halving rounds toward zero, so negative values are biased by one first.
  assign bias      = $signed(PCM_W'(value[PCM_W-1]));
  assign half      = (value + bias) >>> 1;
  assign value_ext = SUM_W'(value);
  assign half_ext  = SUM_W'(half);
  assign pos_inc   = CHAN_W'(pos_q) + CHAN_W'(1);

  always_comb begin
    if (pos_q == '0) begin
      left_new  = left_sum_q + value_ext;
      right_new = right_sum_q;
    end else if (pos_q == POS_W'(1)) begin
      left_new  = left_sum_q;
      right_new = right_sum_q + value_ext;
    end else begin
      left_new  = left_sum_q + half_ext;
      right_new = right_sum_q + half_ext;
    end
  end

  assign left_sat  = clamp16(left_new);
  assign advance_o = stage_i.valid && (!out_valid_q || result_o.ready);

  always_comb begin
    left_sum_d  = left_sum_q;
    right_sum_d = right_sum_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !result_o.ready;
    left_d      = left_q;
    right_d     = right_q;
    if (advance_o) begin
      out_valid_d = 1'b0;
      if (size_ok) begin
        if (pos_inc >= chans) begin
          out_valid_d = 1'b1;
          left_d      = left_sat;
          right_d     = (chans == CHAN_W'(1)) ? left_sat : clamp16(right_new);
          left_sum_d  = '0;
          right_sum_d = '0;
          pos_d       = '0;
        end else begin
          left_sum_d  = left_new;
          right_sum_d = right_new;
          pos_d       = pos_inc[POS_W-1:0];
        end
      end
      if (stage_i.item.end_of_block) begin
        left_sum_d  = '0;
        right_sum_d = '0;
        pos_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_sum_q  <= '0;
      right_sum_q <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      left_sum_q  <= left_sum_d;
      right_sum_q <= right_sum_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q  <= left_d;
    right_q <= right_d;
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.left_out  = left_q;
  assign result_o.right_out = right_q;

endmodule

### hw/rtl/pcm_to_stereo16_downmix_unit.sv
// ----------------------------------------------------------------------------
// PCM to stereo 16-bit downmix unit
// Converts interleaved PCM channel samples and folds each frame to stereo.
// ----------------------------------------------------------------------------
// One channel sample is accepted per cycle while the result register is free
// or its frame is being taken. A sample is held in the input register and
// passes to the result register when the core advances, so a frame result is
// presented from the result register after the transfer of its last sample.
// The combinational convert, accumulate and saturate path sustains one sample
// per clock while results are taken. The result register holds a frame until
// it is taken while the next sample waits in the input register. Channels 0
// and 1 feed left and right, further channels add half their value to both
// sides, and a mono frame is copied to both sides. A sample marked as the end
// of a block discards any partial frame. Registers: sample_bytes at address 0,
// channel_count at address 4.
module pcm_to_stereo16_downmix_unit #(
  parameter int unsigned MAX_CHANNELS = pcmdm_pkg::MAX_CHANNELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pcmdm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pcmdm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pcmdm_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready,
  pcmdm_sample_if.sink                     sample_i,
  pcmdm_result_if.source                   result_o
);
  import pcmdm_pkg::*;

  pcmdm_cfg_t   cfg;
  pcmdm_stage_t stage;
  logic         advance;

  pcmdm_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pcmdm_input_stage u_input_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  (sample_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  pcmdm_core #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .stage_i   (stage),
    .advance_o (advance),
    .result_o  (result_o)
  );

endmodule

### hw/rtl/pcmdm_checker.sv
// ----------------------------------------------------------------------------
// PCM downmix port checker
// Concurrent checks on the top-level ports, bound to the downmix unit.
// ----------------------------------------------------------------------------
module pcmdm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [pcmdm_pkg::PCM_W-1:0]      left_i,
  input logic [pcmdm_pkg::PCM_W-1:0]      right_i,
  input logic                             psel_i,
  input logic                             penable_i,
  input logic                             pwrite_i,
  input logic [pcmdm_pkg::APB_ADDR_W-1:0] paddr_i,
  input logic [pcmdm_pkg::APB_DATA_W-1:0] pwdata_i,
  input logic [pcmdm_pkg::APB_DATA_W-1:0] prdata_i
);
  import pcmdm_pkg::*;

  logic in_xfer;
  logic cfg_wr;

  assign in_xfer = in_valid_i && in_ready_i;
  assign cfg_wr  = psel_i && penable_i && pwrite_i;

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(left_i) && $stable(right_i))
    else $error("stalled result transfer changed");

  a_result_follows_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_xfer, 2))
    else $error("result appeared without a sample transfer two cycles earlier");

  a_sample_bytes_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && !paddr_i[2] |=> paddr_i[2] || (prdata_i[SB_W-1:0] == $past(pwdata_i[SB_W-1:0])))
    else $error("sample_bytes readback does not match last write");

  a_channel_count_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && paddr_i[2] |=> !paddr_i[2] || (prdata_i[CC_W-1:0] == $past(pwdata_i[CC_W-1:0])))
    else $error("channel_count readback does not match last write");

endmodule

bind pcm_to_stereo16_downmix_unit pcmdm_checker u_pcmdm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .left_i      (result_o.left_out),
  .right_i     (result_o.right_out),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);

### dv/testbench.sv
// ----------------------------------------------------------------------------
// PCM to stereo 16-bit downmix unit testbench
// Writes sample size and channel count over the register port, streams raw
// channel samples into the unit and checks every stereo frame it returns
// against a frame predictor kept alongside the stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import pcmdm_pkg::*;

  localparam int unsigned RESET_CYCLES     = 8;
  localparam int unsigned LATENCY_SLACK    = 4;
  localparam int unsigned HOLD_CYCLES      = 200;
  localparam int unsigned RANDOM_ITEMS     = 500;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam int unsigned DEFAULT_CHANNELS = 2;
  localparam int unsigned TIMEOUT_NS       = 2_000_000;

  typedef struct packed {
    logic signed [PCM_W-1:0] left;
    logic signed [PCM_W-1:0] right;
  } stereo_frame_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pcmdm_sample_if smp ();
  pcmdm_result_if res ();

  pcm_to_stereo16_downmix_unit DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .sample_i (smp),
    .result_o (res)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  pcmdm_item_t   pending_samples[$];
  stereo_frame_t expected_frames[$];
  stereo_frame_t predicted_frame;
  stereo_frame_t expected_frame;
  stereo_frame_t returned_frame;

  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 86;
  int unsigned mismatches    = 0;
  logic        hold_armed    = 1'b0;
  logic        result_hold   = 1'b0;

  pcmdm_cfg_t                mix_cfg   = '{sample_bytes: SB_RESET, channel_count: CC_RESET};
  logic signed [SUM_W-1:0]   mix_left  = '0;
  logic signed [SUM_W-1:0]   mix_right = '0;
  logic        [CHAN_W-1:0]  frame_pos = '0;

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] %s", $time, msg);
    end
  endtask

  function automatic int unsigned active_channels();
    int unsigned chans;
    chans = (mix_cfg.channel_count == '0) ? DEFAULT_CHANNELS : int'(mix_cfg.channel_count);
    if (chans > MAX_CHANNELS_DEF) begin
      chans = MAX_CHANNELS_DEF;
    end
    return chans;
  endfunction

  function automatic logic signed [PCM_W-1:0] saturate(input logic signed [SUM_W-1:0] sum);
    if (sum < PCM_MIN) begin
      return PCM_W'(PCM_MIN);
    end
    if (sum > PCM_MAX) begin
      return PCM_W'(PCM_MAX);
    end
    return sum[PCM_W-1:0];
  endfunction

  function automatic bit fold_sample(input pcmdm_item_t it, output stereo_frame_t frame);
    logic signed [PCM_W-1:0] pcm;
    logic signed [PCM_W-1:0] half;
    int unsigned             chans;
    bit                      sized;
    bit                      emit;
    sized = 1'b1;
    emit  = 1'b0;
    frame = '0;
    pcm   = '0;
    chans = active_channels();
    case (mix_cfg.sample_bytes)
      SB_ONE:   pcm = {it.sample_word[7:0] - U8_OFFSET, 8'h00};
      SB_TWO:   pcm = it.sample_word[15:0];
      SB_THREE: pcm = it.sample_word[23:8];
      SB_FOUR:  pcm = it.sample_word[31:16];
      default:  sized = 1'b0;
    endcase
    if (sized) begin
      half = pcm / 2;
      if (frame_pos == 0) begin
        mix_left = mix_left + SUM_W'(pcm);
      end else if (frame_pos == 1) begin
        mix_right = mix_right + SUM_W'(pcm);
      end else begin
        mix_left  = mix_left + SUM_W'(half);
        mix_right = mix_right + SUM_W'(half);
      end
      frame_pos = frame_pos + 1'b1;
      if (frame_pos >= chans) begin
        frame.left  = saturate(mix_left);
        frame.right = (chans == 1) ? frame.left : saturate(mix_right);
        emit        = 1'b1;
        mix_left    = '0;
        mix_right   = '0;
        frame_pos   = '0;
      end
    end
    if (it.end_of_block) begin
      mix_left  = '0;
      mix_right = '0;
      frame_pos = '0;
    end
    return emit;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      smp.valid        <= 1'b0;
      smp.sample_word  <= '0;
      smp.end_of_block <= 1'b0;
    end else if (!smp.valid || smp.ready) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        smp.valid                           <= 1'b1;
        {smp.sample_word, smp.end_of_block} <= pending_samples.pop_front();
      end else begin
        smp.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      res.ready <= !result_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : result_hold_off
    wait (hold_armed);
    @(posedge clk_i);
    result_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    result_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (smp.valid && smp.ready) begin
        if (fold_sample({smp.sample_word, smp.end_of_block}, predicted_frame)) begin
          expected_frames.push_back(predicted_frame);
        end
      end
      if (res.valid && res.ready) begin
        returned_frame.left  = res.left_out;
        returned_frame.right = res.right_out;
        if (expected_frames.size() == 0) begin
          flag_error($sformatf("unexpected frame: left %0d, right %0d",
                               returned_frame.left, returned_frame.right));
        end else begin
          expected_frame = expected_frames.pop_front();
          if (returned_frame.left !== expected_frame.left) begin
            flag_error($sformatf("left_out: expected %0d, got %0d",
                                 expected_frame.left, returned_frame.left));
          end
          if (returned_frame.right !== expected_frame.right) begin
            flag_error($sformatf("right_out: expected %0d, got %0d",
                                 expected_frame.right, returned_frame.right));
          end
        end
      end
    end
  end

  task automatic reg_write(input pcmdm_reg_e idx, input logic [APB_DATA_W-1:0] val);
    logic [APB_DATA_W-1:0] readback;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_SAMPLE_BYTES) begin
      mix_cfg.sample_bytes = val[SB_W-1:0];
    end else begin
      mix_cfg.channel_count = val[CC_W-1:0];
    end
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== val) begin
      flag_error($sformatf("register %s read back %0h, written %0h",
                           idx.name(), readback, val));
    end
  endtask

  task automatic set_config(input logic [SB_W-1:0] sb, input logic [CC_W-1:0] cc);
    reg_write(REG_SAMPLE_BYTES, APB_DATA_W'(sb));
    reg_write(REG_CHANNEL_COUNT, APB_DATA_W'(cc));
  endtask

  task automatic push_sample(input logic [SAMPLE_W-1:0] word, input logic eob);
    pcmdm_item_t it;
    it.sample_word  = word;
    it.end_of_block = eob;
    pending_samples.push_back(it);
  endtask

  task automatic queue_frames(input int unsigned n);
    pcmdm_item_t it;
    int unsigned chans;
    int unsigned slot;
    bit          loud_pos;
    chans    = active_channels();
    slot     = 0;
    loud_pos = 1'b0;
    repeat (n) begin
      if (slot == 0) begin
        loud_pos = $urandom_range(1);
      end
      it.sample_word  = $urandom();
      it.end_of_block = 1'b0;
      if ($urandom_range(1) == 0) begin
        case (mix_cfg.sample_bytes)
          SB_ONE:   it.sample_word[7:0]   = loud_pos ? 8'hFF : 8'h00;
          SB_TWO:   it.sample_word[15:0]  = loud_pos ? 16'h7FFF : 16'h8000;
          SB_THREE: it.sample_word[23:8]  = loud_pos ? 16'h7FFF : 16'h8000;
          SB_FOUR:  it.sample_word[31:16] = loud_pos ? 16'h7FFF : 16'h8000;
          default:  it.sample_word = it.sample_word;
        endcase
      end
      slot++;
      if (slot == chans) begin
        slot            = 0;
        it.end_of_block = ($urandom_range(5) == 0);
      end else if ($urandom_range(39) == 0) begin
        slot            = 0;
        it.end_of_block = 1'b1;
      end
      pending_samples.push_back(it);
    end
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || smp.valid || expected_frames.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (LATENCY_SLACK) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned       counted;
    int unsigned       n;
    int unsigned       pick;
    int unsigned       group;
    logic [SB_W-1:0]   sb;
    logic [CC_W-1:0]   cc;
    smp.valid        = 1'b0;
    smp.sample_word  = '0;
    smp.end_of_block = 1'b0;
    res.ready        = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    rst_ni           = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_sample(32'h0000_7FFF, 1'b0);
    push_sample(32'h0000_8000, 1'b0);
    push_sample(32'h1234_5678, 1'b1);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h0000_0000, 1'b1);
    drain();

    set_config(SB_ONE, 4'd1);
    push_sample(32'hFFFF_FF00, 1'b0);
    push_sample(32'h0000_00FF, 1'b0);
    push_sample(32'h0000_0080, 1'b0);
    drain();

    set_config(SB_FOUR, 4'd15);
    repeat (7) push_sample(32'h7FFF_0000, 1'b0);
    push_sample(32'h7FFF_1234, 1'b1);
    drain();

    set_config(SB_THREE, 4'd0);
    push_sample(32'hFF80_00FF, 1'b0);
    push_sample(32'h0080_0000, 1'b0);
    drain();

    set_config(SB_W'(5), 4'd2);
    push_sample(32'h7FFF_7FFF, 1'b0);
    push_sample(32'h8000_8000, 1'b1);
    drain();

    set_config(SB_TWO, 4'd8);
    repeat (5) push_sample($urandom(), 1'b0);
    drain();
    set_config(SB_TWO, 4'd2);
    push_sample($urandom(), 1'b0);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(SB_TWO, 4'd1);
    hold_armed = 1'b1;
    queue_frames(40);
    drain();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      group         = counted * 3 / RANDOM_ITEMS;
      send_idle_pct = (group == 0) ? 6 : (group == 1) ? 86 : 0;
      recv_idle_pct = (group == 0) ? 86 : (group == 1) ? 6 : 0;
      pick          = $urandom_range(9);
      if (pick == 0) begin
        sb = ($urandom_range(3) == 0) ? SB_W'(0) : SB_W'(SB_FOUR + $urandom_range(1, 3));
      end else begin
        sb = SB_W'($urandom_range(SB_FOUR, SB_ONE));
      end
      case ($urandom_range(3))
        0:       cc = CC_W'($urandom_range(15));
        1:       cc = CC_W'(1);
        2:       cc = CC_W'(MAX_CHANNELS_DEF);
        default: cc = CC_W'($urandom_range(4, 2));
      endcase
      set_config(sb, cc);
      if (pick == 0) begin
        queue_frames(8);
        drain();
      end else begin
        n = $urandom_range(60, 20);
        if ($urandom_range(3) == 0) begin
          queue_frames(n / 2);
          drain();
          queue_frames(n - n / 2);
        end else begin
          queue_frames(n);
        end
        drain();
        counted += n;
      end
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
